// ----- src/afa_pkg.sv -----
// Shared constants and types for the ASID allocator.
`default_nettype none

package afa_pkg;

  // Fixed field widths of the command and result words
  localparam int unsigned SpaceW   = 10;
  localparam int unsigned AsidOutW = 8;

  // Command opcodes
  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef logic [SpaceW-1:0]   space_t;
  typedef logic [AsidOutW-1:0] asid_out_t;

endpackage

`default_nettype wire

// ----- src/asid_fifo_allocator.sv -----
// ASID allocator for one CPU with FIFO replacement: sequencer and both tables.
// Release of an unheld space or a hit answers after the space-table read; release of a held
// ASID also reads the owner table; a fresh ASID reads each candidate's owner, passing over
// those of the running space; an out-of-range space is answered from idle. One word at a
// time; busy stays high until the result strobe, as every step waits on the registered read
// of the owner or space table. Reset clears the owner valid flops at once and then sweeps
// the space table, one entry a cycle with busy high; the receiver cannot stall results.
`default_nettype none

module asid_fifo_allocator #(
  parameter int unsigned ASID_COUNT  = 256,
  parameter int unsigned SPACE_COUNT = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 opcode_i,
  input  wire afa_pkg::space_t      space_id_i,
  input  wire afa_pkg::space_t      current_space_i,
  output logic                      done_o,
  output afa_pkg::asid_out_t        asid_value_o,
  output logic                      flush_needed_o,
  output logic                      evicted_o,
  output afa_pkg::space_t           victim_space_o
);

  localparam int unsigned AW = $clog2(ASID_COUNT);
  localparam int unsigned SW = $clog2(SPACE_COUNT);
  localparam int unsigned TW = AW + 1;

  localparam logic [AW-1:0] AsidLast  = AW'(ASID_COUNT - 1);
  localparam logic [SW-1:0] SpaceLast = SW'(SPACE_COUNT - 1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SP    = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_CAND  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [SW-1:0]       clr_q, clr_d;
  logic                skip_zero_q;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       c_q, c_d;
  logic [TW-1:0]       tries_q, tries_d;
  logic                op_q, op_d;
  afa_pkg::space_t     sp_q, sp_d, cur_q, cur_d;
  logic                ev_q, ev_d;
  afa_pkg::space_t     vic_q, vic_d;
  logic [ASID_COUNT-1:0] own_vld_q;
  logic                own_set, own_clr;
  logic [AW-1:0]       own_idx;

  // Result registers
  logic                done_q, done_d;
  afa_pkg::asid_out_t  res_asid_q, res_asid_d;
  logic                res_flush_q, res_flush_d;
  logic                res_ev_q, res_ev_d;
  afa_pkg::space_t     res_vic_q, res_vic_d;

  // Table ports
  logic                sp_we;
  logic [SW-1:0]       sp_waddr;
  logic [AW:0]         sp_wdata;
  logic [AW:0]         sp_rdata;
  logic                own_we;
  logic [AW-1:0]       own_raddr;
  afa_pkg::space_t     own_rdata;

  // Candidate from the FIFO pointer
  logic [AW-1:0]       cand_c, cand_next;
  logic                own_hit, own_match;
  logic                in_range;

  afa_ram #(.WIDTH(AW + 1), .DEPTH(SPACE_COUNT)) u_space_ram (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata),
    .raddr_i (SW'(space_id_i)),
    .rdata_o (sp_rdata)
  );

  afa_ram #(.WIDTH(afa_pkg::SpaceW), .DEPTH(ASID_COUNT)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (c_q),
    .wdata_i (sp_q),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  // Offer the next candidate, passing over zero when reserved
  always_comb begin
    cand_c = ptr_q;
    if (skip_zero_q && (ptr_q == '0)) begin
      cand_c = AW'(1);
    end
    cand_next = (cand_c == AsidLast) ? '0 : cand_c + AW'(1);
  end

  assign in_range  = (32'(space_id_i) < SPACE_COUNT);
  assign own_match = (own_rdata == cur_q);
  assign own_hit   = own_vld_q[c_q];

  // Sequence one command word through the tables
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ptr_d       = ptr_q;
    c_d         = c_q;
    tries_d     = tries_q;
    op_d        = op_q;
    sp_d        = sp_q;
    cur_d       = cur_q;
    ev_d        = ev_q;
    vic_d       = vic_q;
    done_d      = 1'b0;
    res_asid_d  = '0;
    res_flush_d = 1'b0;
    res_ev_d    = 1'b0;
    res_vic_d   = '0;
    sp_we       = 1'b0;
    sp_waddr    = SW'(sp_q);
    sp_wdata    = '0;
    own_we      = 1'b0;
    own_raddr   = cand_c;
    own_set     = 1'b0;
    own_clr     = 1'b0;
    own_idx     = c_q;

    unique case (state_q)
      S_CLEAR: begin
        sp_we    = 1'b1;
        sp_waddr = clr_q;
        clr_d    = clr_q + SW'(1);
        if (clr_q == SpaceLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_d  = opcode_i;
          sp_d  = space_id_i;
          cur_d = current_space_i;
          if (in_range) begin
            state_d = S_SP;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      S_SP: begin
        if (op_q == afa_pkg::OP_RELEASE) begin
          if (sp_rdata[AW]) begin
            // Drop the space entry, then check the owner
            sp_we     = 1'b1;
            own_raddr = sp_rdata[AW-1:0];
            c_d       = sp_rdata[AW-1:0];
            state_d   = S_REL;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sp_rdata[AW]) begin
          done_d     = 1'b1;
          res_asid_d = afa_pkg::AsidOutW'(sp_rdata[AW-1:0]);
          state_d    = S_IDLE;
        end else begin
          c_d     = cand_c;
          ptr_d   = cand_next;
          tries_d = '0;
          ev_d    = 1'b0;
          vic_d   = '0;
          state_d = S_CAND;
        end
      end
      S_REL: begin
        if (own_hit && (own_rdata == sp_q)) begin
          own_clr = 1'b1;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_CAND: begin
        if (own_hit && own_match && (32'(tries_q) < ASID_COUNT)) begin
          // Pass over an ASID of the running space
          c_d     = cand_c;
          ptr_d   = cand_next;
          tries_d = tries_q + TW'(1);
        end else begin
          if (own_hit && !own_match) begin
            sp_we    = 1'b1;
            sp_waddr = SW'(own_rdata);
            ev_d     = 1'b1;
            vic_d    = own_rdata;
          end
          own_we  = 1'b1;
          own_set = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        sp_we       = 1'b1;
        sp_wdata    = {1'b1, c_q};
        done_d      = 1'b1;
        res_asid_d  = afa_pkg::AsidOutW'(c_q);
        res_flush_d = 1'b1;
        res_ev_d    = ev_q;
        res_vic_d   = vic_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      skip_zero_q <= 1'b1;
      ptr_q       <= '0;
      own_vld_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        skip_zero_q <= cfg_wdata_i;
      end
      if (own_set) begin
        own_vld_q[own_idx] <= 1'b1;
      end else if (own_clr) begin
        own_vld_q[own_idx] <= 1'b0;
      end
    end
  end

  // Hold payload state
  always_ff @(posedge clk_i) begin
    c_q         <= c_d;
    tries_q     <= tries_d;
    op_q        <= op_d;
    sp_q        <= sp_d;
    cur_q       <= cur_d;
    ev_q        <= ev_d;
    vic_q       <= vic_d;
    res_asid_q  <= res_asid_d;
    res_flush_q <= res_flush_d;
    res_ev_q    <= res_ev_d;
    res_vic_q   <= res_vic_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign asid_value_o   = res_asid_q;
  assign flush_needed_o = res_flush_q;
  assign evicted_o      = res_ev_q;
  assign victim_space_o = res_vic_q;

endmodule

`default_nettype wire

// ----- src/afa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module afa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write the addressed entry, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
